// ===== hdl/thbt_pkg.sv =====
// Shared types, widths and constants for the thermistor beta temperature block.
package thbt_pkg;

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned SER_W      = 20;
  localparam int unsigned NOM_W      = 20;
  localparam int unsigned BETA_W     = 16;
  localparam int unsigned TNOM_W     = 15;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned ADC_FULL_SCALE = 1023;

  localparam int unsigned DIV_W      = 48;
  localparam int unsigned SQ_STEPS   = 24;
  localparam int unsigned MANT_W     = 31;
  localparam int unsigned EXP_W      = 6;
  localparam int unsigned LOG_W      = EXP_W + SQ_STEPS;
  localparam int unsigned LN_W       = LOG_W;
  localparam int unsigned BETA_SHIFT = 16;

  localparam logic [EXP_W-1:0] NORM_POS   = EXP_W'(MANT_W - 1);
  localparam logic [31:0]      LN2_Q32    = 32'd2977044472;
  localparam logic [DIV_W-1:0] HUNDRED_Q40 = 48'h6400_0000_0000;

  localparam int KELVIN_CENTI = 27315;
  localparam int TEMP_MAX     = 32767;
  localparam int TCK_MAX      = TEMP_MAX + KELVIN_CENTI;

  localparam logic [SER_W-1:0]         SER_RESET  = 20'd10000;
  localparam logic [NOM_W-1:0]         NOM_RESET  = 20'd10000;
  localparam logic [BETA_W-1:0]        BETA_RESET = 16'd3950;
  localparam logic signed [TNOM_W-1:0] TNOM_RESET = 15'sd2500;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OVER = 2'd2,
    ST_ZERO = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERIES = 2'd0,
    CFG_NOMINAL = 2'd1,
    CFG_BETA   = 2'd2,
    CFG_TNOM   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    status_t status;
    logic    neg;
    logic    sat;
  } side_t;

endpackage

// ===== hdl/thbt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module thbt_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [thbt_pkg::DIV_W-1:0] n_i,
  input  logic [thbt_pkg::DIV_W-1:0] d_i,
  output logic [thbt_pkg::DIV_W-1:0] q_o
);
  import thbt_pkg::*;

  logic [DIV_W-1:0] rem_r  [DIV_W-1];
  logic [DIV_W-1:0] d_r    [DIV_W-1];
  logic [DIV_W-1:0] nq_r   [DIV_W];
  logic [DIV_W-1:0] rem_nxt[DIV_W];
  logic [DIV_W-1:0] d_nxt  [DIV_W];
  logic [DIV_W-1:0] nq_nxt [DIV_W];

  always_comb begin
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] nq_in;
    logic [DIV_W-1:0] d_in;
    logic [DIV_W:0]   t;
    logic [DIV_W:0]   sub;
    logic             ge;
    for (int s = 0; s < DIV_W; s++) begin
      if (s == 0) begin
        rem_in = '0;
        nq_in  = n_i;
        d_in   = d_i;
      end else begin
        rem_in = rem_r[s-1];
        nq_in  = nq_r[s-1];
        d_in   = d_r[s-1];
      end
      t  = {rem_in, nq_in[DIV_W-1]};
      sub = t - {1'b0, d_in};
      ge = (t >= {1'b0, d_in});
      rem_nxt[s] = ge ? sub[DIV_W-1:0] : t[DIV_W-1:0];
      nq_nxt[s]  = {nq_in[DIV_W-2:0], ge};
      d_nxt[s]   = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_W; s++) begin
        nq_r[s] <= nq_nxt[s];
      end
      for (int s = 0; s < DIV_W - 1; s++) begin
        rem_r[s] <= rem_nxt[s];
        d_r[s]   <= d_nxt[s];
      end
    end
  end

  assign q_o = nq_r[DIV_W-1];

endmodule

// ===== hdl/thermistor_beta_temperature.sv =====
// Thermistor temperature by the beta equation, fully pipelined.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_adc_count
//   out_     output     out_valid / out_ready  out_temp_centi, out_status
//   cfg_     input      cfg_wr_en              cfg_index, cfg_data
//
// One item per cycle while the skid stage is empty; an item passes a
// 48-stage divider, a 24-stage log2 squaring chain and two divider ranks.
// Synchronous reset loads the default registers and empties the pipeline.
// An output register and a one-entry skid stage decouple the result side;
// the pipeline holds only while the skid stage is full.
module thermistor_beta_temperature (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [thbt_pkg::CNT_W-1:0]          in_adc_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [thbt_pkg::TEMP_W-1:0]  out_temp_centi,
  output logic [thbt_pkg::STAT_W-1:0]         out_status,
  input  logic                                cfg_wr_en,
  input  logic [thbt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [thbt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import thbt_pkg::*;

  localparam int J_Q1   = DIV_W;
  localparam int J_X    = J_Q1 + 1;
  localparam int J_E    = J_X + 1;
  localparam int J_M    = J_E + 1;
  localparam int J_LN   = J_M + SQ_STEPS + 1;
  localparam int J_D2   = J_LN + 1;
  localparam int J_Q2   = J_D2 + DIV_W;
  localparam int J_SUM  = J_Q2 + 1;
  localparam int J_D4   = J_SUM + 1;
  localparam int J_Q4   = J_D4 + DIV_W;
  localparam int SB_LEN = J_Q4 + 1;
  localparam int LANES  = 2;

  localparam logic [CNT_W-1:0] FS_CNT    = CNT_W'(ADC_FULL_SCALE);
  localparam logic [61:0]      ROUND_Q32 = 62'd2147483648;

  logic [SER_W-1:0]         ser_r;
  logic [NOM_W-1:0]         nom_r;
  logic [BETA_W-1:0]        beta_r;
  logic signed [TNOM_W-1:0] tnom_r;

  logic en;
  logic skid_valid_r;

  side_t sb_in      [SB_LEN];
  side_t sb_r       [SB_LEN];
  logic  sb_valid_r [SB_LEN];

  status_t in_status;

  logic [DIV_W-1:0] n1_r, d1_r, q1;
  logic [DIV_W-1:0] rth;
  logic [NOM_W-1:0] nom_eff;

  logic [DIV_W-1:0]  x_r   [LANES];
  logic [DIV_W-1:0]  x2_r  [LANES];
  logic [EXP_W-1:0]  e2_r  [LANES];
  logic [EXP_W-1:0]  e_c   [LANES];
  logic [MANT_W-1:0] m_c   [LANES];

  logic [MANT_W-1:0]   m_r   [LANES][SQ_STEPS+1];
  logic [SQ_STEPS-1:0] f_r   [LANES][SQ_STEPS+1];
  logic [EXP_W-1:0]    e_r   [LANES][SQ_STEPS+1];
  logic [MANT_W-1:0]   m_nxt [LANES][SQ_STEPS+1];
  logic [SQ_STEPS-1:0] f_nxt [LANES][SQ_STEPS+1];

  logic [LN_W-1:0] ln_r [LANES];

  logic signed [LN_W:0] lr;
  logic                 lr_neg;
  logic [LN_W-1:0]      lr_mag;
  logic [BETA_W-1:0]    beta_eff;
  logic signed [16:0]   kc;
  logic [15:0]          k16;

  logic [DIV_W-1:0] n2_r, d2_r, n3_r, d3_r, q2, q3;
  logic signed [DIV_W:0] term;
  logic signed [DIV_W:0] sum_r;
  logic                  sum_le0;
  logic [DIV_W-1:0]      n4_r, d4_r, q4;

  logic                     p_valid;
  status_t                  p_status;
  logic signed [TEMP_W-1:0] p_temp;

  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] out_temp_r, skid_temp_r;
  logic [STAT_W-1:0]        out_status_r, skid_status_r;
  logic                     out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_r  <= SER_RESET;
      nom_r  <= NOM_RESET;
      beta_r <= BETA_RESET;
      tnom_r <= TNOM_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SERIES:  ser_r  <= cfg_data[SER_W-1:0];
        CFG_NOMINAL: nom_r  <= cfg_data[NOM_W-1:0];
        CFG_BETA:    beta_r <= cfg_data[BETA_W-1:0];
        CFG_TNOM:    tnom_r <= cfg_data[TNOM_W-1:0];
        default:     ser_r  <= ser_r;
      endcase
    end
  end

  assign in_ready = ~skid_valid_r;
  assign en       = in_ready;

  always_comb begin
    if (in_adc_count == FS_CNT) begin
      in_status = ST_FULL;
    end else if (in_adc_count > FS_CNT) begin
      in_status = ST_OVER;
    end else begin
      in_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r <= DIV_W'(ser_r) * DIV_W'(ADC_FULL_SCALE);
      d1_r <= DIV_W'(FS_CNT - in_adc_count);
    end
  end

  thbt_div u_div_res (.clk(clk), .en(en), .n_i(n1_r), .d_i(d1_r), .q_o(q1));

  assign rth     = q1 - DIV_W'(ser_r);
  assign nom_eff = (nom_r == '0) ? NOM_W'(1) : nom_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= rth;
      x_r[1] <= DIV_W'(nom_eff);
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      e_c[l] = '0;
      for (int i = 0; i < DIV_W; i++) begin
        if (x_r[l][i]) begin
          e_c[l] = EXP_W'(i);
        end
      end
    end
  end

  always_comb begin
    logic [DIV_W-1:0] ms;
    for (int l = 0; l < LANES; l++) begin
      if (e2_r[l] <= NORM_POS) begin
        ms = x2_r[l] << (NORM_POS - e2_r[l]);
      end else begin
        ms = x2_r[l] >> (e2_r[l] - NORM_POS);
      end
      m_c[l] = ms[MANT_W-1:0];
    end
  end

  always_comb begin
    logic [61:0] sq;
    logic [31:0] t;
    for (int l = 0; l < LANES; l++) begin
      m_nxt[l][0] = m_c[l];
      f_nxt[l][0] = '0;
      for (int k = 1; k <= SQ_STEPS; k++) begin
        sq = 62'(m_r[l][k-1]) * 62'(m_r[l][k-1]);
        t  = sq[61:30];
        m_nxt[l][k] = t[31] ? t[31:1] : t[30:0];
        f_nxt[l][k] = {f_r[l][k-1][SQ_STEPS-2:0], t[31]};
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [61:0] prod;
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        x2_r[l] <= x_r[l];
        e2_r[l] <= e_c[l];
        e_r[l][0] <= e2_r[l];
        for (int k = 0; k <= SQ_STEPS; k++) begin
          m_r[l][k] <= m_nxt[l][k];
          f_r[l][k] <= f_nxt[l][k];
          if (k > 0) begin
            e_r[l][k] <= e_r[l][k-1];
          end
        end
        prod = 62'({e_r[l][SQ_STEPS], f_r[l][SQ_STEPS]}) * 62'(LN2_Q32) + ROUND_Q32;
        ln_r[l] <= prod[61:32];
      end
    end
  end

  assign lr       = $signed({1'b0, ln_r[0]}) - $signed({1'b0, ln_r[1]});
  assign lr_neg   = lr[LN_W];
  assign lr_mag   = lr_neg ? LN_W'(-lr) : LN_W'(lr);
  assign beta_eff = (beta_r == '0) ? BETA_W'(1) : beta_r;
  assign kc       = 17'(tnom_r) + 17'sd27315;
  assign k16      = kc[15:0];

  always_ff @(posedge clk) begin
    if (en) begin
      n2_r <= (DIV_W'(lr_mag) << BETA_SHIFT) + DIV_W'(beta_eff >> 1);
      d2_r <= DIV_W'(beta_eff);
      n3_r <= HUNDRED_Q40 + DIV_W'(k16 >> 1);
      d3_r <= DIV_W'(k16);
    end
  end

  thbt_div u_div_beta (.clk(clk), .en(en), .n_i(n2_r), .d_i(d2_r), .q_o(q2));
  thbt_div u_div_tnom (.clk(clk), .en(en), .n_i(n3_r), .d_i(d3_r), .q_o(q3));

  assign term = sb_r[J_Q2].neg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= term + $signed({1'b0, q3});
    end
  end

  assign sum_le0 = sum_r[DIV_W] | (sum_r == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      n4_r <= HUNDRED_Q40 + (sum_r[DIV_W-1:0] >> 1);
      d4_r <= sum_r[DIV_W-1:0];
    end
  end

  thbt_div u_div_temp (.clk(clk), .en(en), .n_i(n4_r), .d_i(d4_r), .q_o(q4));

  always_comb begin
    sb_in[0] = '{status: in_status, neg: 1'b0, sat: 1'b0};
    for (int j = 1; j < SB_LEN; j++) begin
      sb_in[j] = sb_r[j-1];
    end
    if (sb_r[J_Q1].status == ST_OK && rth == '0) begin
      sb_in[J_X].status = ST_ZERO;
    end
    sb_in[J_D2].neg = lr_neg;
    sb_in[J_D4].sat = sum_le0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SB_LEN; j++) begin
        sb_valid_r[j] <= 1'b0;
      end
    end else if (en) begin
      sb_valid_r[0] <= in_valid;
      for (int j = 1; j < SB_LEN; j++) begin
        sb_valid_r[j] <= sb_valid_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SB_LEN; j++) begin
        sb_r[j] <= sb_in[j];
      end
    end
  end

  assign p_valid  = sb_valid_r[J_Q4];
  assign p_status = sb_r[J_Q4].status;

  always_comb begin
    if (p_status != ST_OK) begin
      p_temp = '0;
    end else if (sb_r[J_Q4].sat || q4 > DIV_W'(TCK_MAX)) begin
      p_temp = TEMP_W'(TEMP_MAX);
    end else begin
      p_temp = $signed(q4[TEMP_W-1:0] - TEMP_W'(KELVIN_CENTI));
    end
  end

  assign out_free = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_r <= p_valid;
    end else if (p_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_temp_r   <= skid_temp_r;
        out_status_r <= skid_status_r;
      end
    end else if (out_free) begin
      out_temp_r   <= p_temp;
      out_status_r <= p_status;
    end else begin
      skid_temp_r   <= p_temp;
      skid_status_r <= p_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_temp_centi = out_temp_r;
  assign out_status     = out_status_r;

endmodule

// ===== sim/thermistor_beta_temperature_test.sv =====
// Testbench for the thermistor beta temperature block: counts checked against a predictor.
`timescale 1ns / 1ps
module thermistor_beta_temperature_test;
  import thbt_pkg::*;

  localparam int LATENCY = 176;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CNT_W-1:0] in_adc_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [TEMP_W-1:0] out_temp_centi;
  logic [STAT_W-1:0] out_status;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [STAT_W-1:0] status;
  } reading_t;

  reading_t pending_readings[$];
  logic [SER_W-1:0] series_ohm;
  logic [NOM_W-1:0] nominal_ohm;
  logic [BETA_W-1:0] beta_k;
  logic [TNOM_W-1:0] nominal_centi;
  int mismatches = 0;
  int sent = 0;
  int received = 0;
  int status_seen[4];
  longint cycles = 0;

  thermistor_beta_temperature dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("thermistor_beta_temperature_test: errors");
      $finish;
    end
  end

  function automatic longint unsigned log2_fixed(longint unsigned x);
    int e;
    longint unsigned t, m, f;
    e = 0;
    t = x;
    f = 0;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      f <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        f |= 1;
      end
    end
    return (longint'(e) << 24) | f;
  endfunction

  function automatic longint ln_fixed(longint unsigned x);
    logic [127:0] p;
    p = 128'(log2_fixed(x)) * 128'(LN2_Q32) + (128'd1 << 31);
    return longint'(p >> 32);
  endfunction

  function automatic reading_t predict_temperature(logic [CNT_W-1:0] count);
    reading_t r;
    longint unsigned fs, sr, rth, nom, bt, mag, q, inv, tck;
    longint lr, term, sum, tnom;
    r = '0;
    fs = ADC_FULL_SCALE;
    sr = series_ohm;
    if (count == fs) begin
      r.status = ST_FULL;
      return r;
    end
    if (count > fs) begin
      r.status = ST_OVER;
      return r;
    end
    rth = (sr * fs) / (fs - count) - sr;
    if (rth == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    nom = nominal_ohm ? nominal_ohm : 1;
    bt = beta_k ? beta_k : 1;
    lr = ln_fixed(rth) - ln_fixed(nom);
    mag = (lr < 0) ? -lr : lr;
    q = ((mag << 16) + bt / 2) / bt;
    term = (lr < 0) ? -longint'(q) : longint'(q);
    tnom = longint'($signed(nominal_centi));
    inv = (64'(HUNDRED_Q40) + (tnom + KELVIN_CENTI) / 2) / (tnom + KELVIN_CENTI);
    sum = term + longint'(inv);
    r.status = ST_OK;
    if (sum <= 0) r.temp = TEMP_W'(TEMP_MAX);
    else begin
      tck = (64'(HUNDRED_Q40) + sum / 2) / sum;
      if (tck > TCK_MAX) r.temp = TEMP_W'(TEMP_MAX);
      else r.temp = TEMP_W'(longint'(tck) - KELVIN_CENTI);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      received++;
      status_seen[out_status]++;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d", out_temp_centi, out_status);
      end else begin
        want = pending_readings.pop_front();
        if (want.temp !== out_temp_centi || want.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected temp %0d status %0d, got temp %0d status %0d",
                     $signed(want.temp), want.status, out_temp_centi, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    int stall;
    if (stall > 0) begin
      out_ready <= 1'b0;
      stall--;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready) stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    end
  end

  task automatic send_count(logic [CNT_W-1:0] count, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_count <= count;
    pending_readings.push_back(predict_temperature(count));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SERIES: series_ohm = value;
      CFG_NOMINAL: nominal_ohm = value;
      CFG_BETA: beta_k = value[BETA_W-1:0];
      default: nominal_centi = value[TNOM_W-1:0];
    endcase
  endtask

  task automatic test_directed;
    logic [CNT_W-1:0] edges[$] = '{0, 1, 2, 511, 512, 1000, 1021, 1022, 1023, 1024,
                                    16'hFFFF, 16'h8000, 16'h5555, 16'h2AA};
    foreach (edges[i]) send_count(edges[i], 1'b0);
    drain();
  endtask

  task automatic test_extreme_settings;
    write_reg(CFG_SERIES, 20'hFFFFF);
    write_reg(CFG_NOMINAL, 20'd1);
    write_reg(CFG_BETA, 20'd1);
    write_reg(CFG_TNOM, 20'(15'sd15000));
    for (int i = 0; i < 6; i++) send_count(CNT_W'($urandom_range(0, 1022)), 1'b1);
    send_count(1, 1'b0);
    send_count(1022, 1'b0);
    drain();
    write_reg(CFG_SERIES, 20'd1);
    write_reg(CFG_NOMINAL, 20'hFFFFF);
    write_reg(CFG_BETA, 20'hFFFF);
    write_reg(CFG_TNOM, 20'(-15'sd5500));
    send_count(1, 1'b0);
    send_count(512, 1'b0);
    send_count(1022, 1'b0);
    drain();
    write_reg(CFG_SERIES, 20'd0);
    write_reg(CFG_NOMINAL, 20'd0);
    write_reg(CFG_BETA, 20'd0);
    send_count(300, 1'b0);
    drain();
    write_reg(CFG_SERIES, 20'd1000);
    send_count(300, 1'b0);
    drain();
  endtask

  task automatic test_random;
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(CFG_SERIES, 20'($urandom_range(1, 20'hFFFFF)));
      write_reg(CFG_NOMINAL, 20'($urandom_range(1, 20'hFFFFF)));
      write_reg(CFG_BETA, 20'($urandom_range(1, 16'hFFFF)));
      write_reg(CFG_TNOM, 20'(TNOM_W'($signed($urandom_range(0, 20500)) - 5500)));
      for (int i = 0; i < 300; i++) begin
        case ($urandom_range(0, 9))
          0: send_count(CNT_W'($urandom), phase != 2);
          1: send_count(CNT_W'($urandom_range(1020, 1026)), phase != 2);
          default: send_count(CNT_W'($urandom_range(0, 1022)),
                              phase != 2 && (i % 100) > 30);
        endcase
      end
      drain();
    end
  endtask

  initial begin
    series_ohm = SER_RESET;
    nominal_ohm = NOM_RESET;
    beta_k = BETA_RESET;
    nominal_centi = TNOM_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extreme_settings();
    test_random();
    $display("sent %0d counts, checked %0d results", sent, received);
    $display("status ok %0d, full scale %0d, over %0d, zero %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("thermistor_beta_temperature_test: clean");
    end else begin
      $display("thermistor_beta_temperature_test: errors");
    end
    $finish;
  end

endmodule

// ===== thermistor_beta_temperature.f =====
hdl/thbt_pkg.sv
hdl/thbt_div.sv
hdl/thermistor_beta_temperature.sv
sim/thermistor_beta_temperature_test.sv
